// ----- design/assert_macros.svh -----
// Assertion helpers included by the controller design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- design/ctic_pkg.sv -----
`default_nettype none

package ctic_pkg;

    typedef enum logic [2:0] {
        FUNC_TICK  = 3'd0,
        FUNC_READ  = 3'd1,
        FUNC_WRITE = 3'd2,
        FUNC_RAISE = 3'd3,
        FUNC_ACK   = 3'd4
    } func_t;

    localparam logic [15:0] ADDR_DIV  = 16'hFF04;
    localparam logic [15:0] ADDR_TIMA = 16'hFF05;
    localparam logic [15:0] ADDR_TMA  = 16'hFF06;
    localparam logic [15:0] ADDR_TAC  = 16'hFF07;
    localparam logic [15:0] ADDR_IF   = 16'hFF0F;
    localparam logic [15:0] ADDR_IE   = 16'hFFFF;

    localparam logic [6:0] VECTOR_BASE   = 7'h40;
    localparam logic [7:0] TIMER_IRQ_BIT = 8'h04;
    localparam logic [7:0] UNMAPPED_DATA = 8'hFF;

    // Counter bit that clocks TIMA for each TAC rate code.
    function automatic logic [3:0] rate_bit(input logic [1:0] rate);
        logic [3:0] bit_sel;
        case (rate)
            2'd0:    bit_sel = 4'd7;
            2'd1:    bit_sel = 4'd1;
            2'd2:    bit_sel = 4'd3;
            2'd3:    bit_sel = 4'd5;
            default: bit_sel = 4'd7;
        endcase
        return bit_sel;
    endfunction

endpackage

`default_nettype wire

// ----- design/cpu_timer_and_interrupt_controller.sv -----
// Timer and interrupt controller for a small 8-bit CPU.
// Input channel: in_valid / in_stall carry one beat per operation: func
// selects tick, register read, register write, interrupt raise or
// interrupt acknowledge; addr, wdata, request_lines and master_enable
// are its operands. Output channel: out_valid / out_stall carry exactly
// one result beat per input beat, in order: rdata, addr_hit, irq_pending,
// vector_valid and vector.
// The beat is captured in an input register; when it moves on, the timer
// and interrupt state is updated and the result is loaded into the output
// register together. Throughput is one beat per cycle while out_stall
// stays low; each beat updates all state as it moves on.
// When the receiver stalls, the output register holds its beat and the
// input register fills; in_stall rises only when both are occupied, so
// no beat is lost or repeated. Reset clears the counter, TIMA, TMA, TAC,
// IF, IE and the edge detector, and empties both pipeline registers.
`default_nettype none
`include "assert_macros.svh"

module cpu_timer_and_interrupt_controller (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [2:0]  func,
    input  wire logic [15:0] addr,
    input  wire logic [7:0]  wdata,
    input  wire logic [4:0]  request_lines,
    input  wire logic        master_enable,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [7:0]       rdata,
    output logic             addr_hit,
    output logic             irq_pending,
    output logic             vector_valid,
    output logic [6:0]       vector
);
    import ctic_pkg::*;

    // Input register.
    logic        s1_valid_reg;
    logic [2:0]  s1_func_reg;
    logic [15:0] s1_addr_reg;
    logic [7:0]  s1_wdata_reg;
    logic [4:0]  s1_req_reg;
    logic        s1_ime_reg;

    // Architectural state.
    logic [15:0] counter_reg, counter_next;
    logic [7:0]  tima_reg, tima_next;
    logic [7:0]  tma_reg, tma_next;
    logic [7:0]  tac_reg, tac_next;
    logic [7:0]  if_reg, if_next;
    logic [7:0]  ie_reg, ie_next;
    logic        gate_reg, gate_next;

    // Output register.
    logic        out_valid_reg;
    logic [7:0]  rdata_reg, rdata_next;
    logic        hit_reg, hit_next;
    logic        pend_reg, pend_next;
    logic        vvalid_reg, vvalid_next;
    logic [6:0]  vector_reg, vector_next;

    logic        advance;
    logic        in_take;
    logic [15:0] counter_inc;
    logic        gate_now;
    logic        tima_fall;
    logic [4:0]  pend_bits;
    logic [2:0]  src;

    // The input register moves on whenever the output register is free
    // or is being emptied in this cycle.
    assign advance  = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    assign counter_inc = counter_reg + 16'd1;
    assign gate_now    = counter_inc[rate_bit(tac_reg[1:0])] & tac_reg[2];
    assign tima_fall   = gate_reg && !gate_now;
    assign pend_bits   = if_reg[4:0] & ie_reg[4:0];

    // Lowest pending source wins.
    always_comb
    begin
        src = 3'd0;
        for (int i = 4; i >= 0; i--)
        begin
            if (pend_bits[i])
            begin
                src = 3'(i);
            end
        end
    end

    always_comb
    begin
        counter_next = counter_reg;
        tima_next    = tima_reg;
        tma_next     = tma_reg;
        tac_next     = tac_reg;
        if_next      = if_reg;
        ie_next      = ie_reg;
        gate_next    = gate_reg;
        rdata_next   = UNMAPPED_DATA;
        hit_next     = 1'b0;
        vvalid_next  = 1'b0;
        vector_next  = 7'd0;

        case (func_t'(s1_func_reg))
            FUNC_TICK:
            begin
                counter_next = counter_inc;
                gate_next    = gate_now;
                if (tima_fall)
                begin
                    if (tima_reg == 8'hFF)
                    begin
                        tima_next = tma_reg;
                        if_next   = if_reg | TIMER_IRQ_BIT;
                    end
                    else
                    begin
                        tima_next = tima_reg + 8'd1;
                    end
                end
            end
            FUNC_READ:
            begin
                hit_next = 1'b1;
                case (s1_addr_reg)
                    ADDR_DIV:  rdata_next = counter_reg[13:6];
                    ADDR_TIMA: rdata_next = tima_reg;
                    ADDR_TMA:  rdata_next = tma_reg;
                    ADDR_TAC:  rdata_next = tac_reg;
                    ADDR_IF:   rdata_next = if_reg;
                    ADDR_IE:   rdata_next = ie_reg;
                    default:   hit_next = 1'b0;
                endcase
            end
            FUNC_WRITE:
            begin
                hit_next = 1'b1;
                case (s1_addr_reg)
                    ADDR_DIV:  counter_next = 16'd0;
                    ADDR_TIMA: tima_next = s1_wdata_reg;
                    ADDR_TMA:  tma_next = s1_wdata_reg;
                    ADDR_TAC:  tac_next = s1_wdata_reg;
                    ADDR_IF:   if_next = s1_wdata_reg;
                    ADDR_IE:   ie_next = s1_wdata_reg;
                    default:   hit_next = 1'b0;
                endcase
            end
            FUNC_RAISE:
            begin
                if_next = if_reg | {3'b000, s1_req_reg};
            end
            FUNC_ACK:
            begin
                if (s1_ime_reg && (pend_bits != 5'd0))
                begin
                    if_next     = if_reg & ~(8'd1 << src);
                    vvalid_next = 1'b1;
                    vector_next = VECTOR_BASE + {1'b0, src, 3'b000};
                end
            end
            default:
            begin
                counter_next = counter_reg;
            end
        endcase

        pend_next = ((if_next[4:0] & ie_next[4:0]) != 5'd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            counter_reg   <= 16'd0;
            tima_reg      <= 8'd0;
            tma_reg       <= 8'd0;
            tac_reg       <= 8'd0;
            if_reg        <= 8'd0;
            ie_reg        <= 8'd0;
            gate_reg      <= 1'b0;
        end
        else
        begin
            if (in_take)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                out_valid_reg <= 1'b1;
                counter_reg   <= counter_next;
                tima_reg      <= tima_next;
                tma_reg       <= tma_next;
                tac_reg       <= tac_next;
                if_reg        <= if_next;
                ie_reg        <= ie_next;
                gate_reg      <= gate_next;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_func_reg  <= func;
            s1_addr_reg  <= addr;
            s1_wdata_reg <= wdata;
            s1_req_reg   <= request_lines;
            s1_ime_reg   <= master_enable;
        end
        if (advance)
        begin
            rdata_reg  <= rdata_next;
            hit_reg    <= hit_next;
            pend_reg   <= pend_next;
            vvalid_reg <= vvalid_next;
            vector_reg <= vector_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign rdata        = rdata_reg;
    assign addr_hit     = hit_reg;
    assign irq_pending  = pend_reg;
    assign vector_valid = vvalid_reg;
    assign vector       = vector_reg;

    `ASSERT_SAME(a_vec_range, clk, rst_n, out_valid && vector_valid,
                 (vector[6] == 1'b1) && (vector[2:0] == 3'd0) && !addr_hit)
    `ASSERT_SAME(a_vec_zero, clk, rst_n, out_valid && !vector_valid, vector == 7'd0)
    `ASSERT_SAME(a_empty_no_stall, clk, rst_n, !s1_valid_reg, !in_stall)
    `ASSERT_NEXT(a_advance_fills, clk, rst_n, advance, out_valid)
    `ASSERT_NEXT(a_timer_irq, clk, rst_n,
                 advance && (s1_func_reg == FUNC_TICK) && tima_fall && (tima_reg == 8'hFF),
                 if_reg[2] && (tima_reg == $past(tma_reg)))

endmodule

`default_nettype wire

// ----- test/cpu_timer_and_interrupt_controller_test.sv -----
`timescale 1ns / 1ps

// Self-checking bench for the timer and interrupt controller.
// Each input beat is scored at acceptance by a software copy of the
// controller state. That copy produces the expected result beat. The result
// channel is then checked in order against the queue of expected beats.
module cpu_timer_and_interrupt_controller_test;

    import ctic_pkg::*;

    // Result fields in port order, so the output ports can be packed
    // straight into this type.
    typedef struct packed {
        logic [7:0] rdata;
        logic       addr_hit;
        logic       irq_pending;
        logic       vector_valid;
        logic [6:0] vector;
    } reply_t;

    typedef struct packed {
        func_t       op;
        logic [15:0] addr;
        logic [7:0]  wdata;
        logic [4:0]  req;
        logic        ime;
    } beat_t;

    // A directed row carries a typed-in result when the result is obvious.
    // Otherwise the predictor supplies the result.
    typedef struct packed {
        beat_t  beat;
        logic   known;
        reply_t reply;
    } script_row_t;

    localparam int TICKS_PER_RATE = 200;     // a few timer edges at every rate
    localparam int RANDOM_BEATS   = 500;
    localparam int CALM_BEATS     = 150;
    localparam int HOLD_CYCLES    = 150;
    localparam int HOLD_AT        = 25 + 4 * (TICKS_PER_RATE + 1) + 200;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int DRAIN_CYCLES   = 8;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic [2:0]  func = FUNC_TICK;
    logic [15:0] addr = '0;
    logic [7:0]  wdata = '0;
    logic [4:0]  request_lines = '0;
    logic        master_enable = 1'b0;
    logic        out_stall = 1'b0;
    logic        in_stall;
    logic        out_valid;
    logic [7:0]  rdata;
    logic        addr_hit;
    logic        irq_pending;
    logic        vector_valid;
    logic [6:0]  vector;

    // This shadow state starts out equal to the reset state of the block.
    logic [15:0] cycle_count = '0;
    logic [7:0]  timer_value = '0;
    logic [7:0]  timer_reload = '0;
    logic [7:0]  timer_ctrl = '0;
    logic [7:0]  flag_reg = '0;
    logic [7:0]  enable_reg = '0;
    logic        gate_last = 1'b0;

    reply_t replies_due [$];
    int     mismatches = 0;
    int     beats_sent = 0;
    int     quiet_cycles = 0;
    int     stall_left = 0;
    int     hold_left = 0;
    bit     held_off = 1'b0;
    bit     idling_on = 1'b1;

    localparam logic [15:0] MAPPED_ADDRS [6] =
        '{ADDR_DIV, ADDR_TIMA, ADDR_TMA, ADDR_TAC, ADDR_IF, ADDR_IE};

    // The directed script opens with the post-reset reads and the unmapped
    // extremes at 0x0000 and 0xFFFE. Next come acknowledge with no source
    // and acknowledge with the master enable off. After that, every vector
    // is taken from 0x40 up to 0x60. The upper flag bits are then stored
    // without raising an interrupt. The script ends with a TIMA wrap that
    // follows a DIV write, which leaves the old gate level behind.
    script_row_t directed_script [25] = '{
        '{'{FUNC_READ,  ADDR_DIV,  8'h00, 5'h00, 1'b0}, 1'b1,
          '{8'h00, 1'b1, 1'b0, 1'b0, 7'h00}},
        '{'{FUNC_READ,  16'h0000,  8'h00, 5'h00, 1'b0}, 1'b1,
          '{8'hFF, 1'b0, 1'b0, 1'b0, 7'h00}},
        '{'{FUNC_WRITE, 16'hFFFE,  8'hFF, 5'h1F, 1'b1}, 1'b1,
          '{8'hFF, 1'b0, 1'b0, 1'b0, 7'h00}},
        '{'{FUNC_READ,  ADDR_IE,   8'h00, 5'h00, 1'b0}, 1'b1,
          '{8'h00, 1'b1, 1'b0, 1'b0, 7'h00}},
        '{'{FUNC_WRITE, ADDR_IE,   8'hFF, 5'h00, 1'b0}, 1'b1,
          '{8'hFF, 1'b1, 1'b0, 1'b0, 7'h00}},
        '{'{FUNC_ACK,   16'h0000,  8'h00, 5'h00, 1'b1}, 1'b1,
          '{8'hFF, 1'b0, 1'b0, 1'b0, 7'h00}},
        '{'{FUNC_RAISE, 16'h0000,  8'h00, 5'h1F, 1'b0}, 1'b1,
          '{8'hFF, 1'b0, 1'b1, 1'b0, 7'h00}},
        '{'{FUNC_ACK,   16'h0000,  8'h00, 5'h00, 1'b0}, 1'b1,
          '{8'hFF, 1'b0, 1'b1, 1'b0, 7'h00}},
        '{'{FUNC_ACK,   16'h0000,  8'h00, 5'h00, 1'b1}, 1'b1,
          '{8'hFF, 1'b0, 1'b1, 1'b1, 7'h40}},
        '{'{FUNC_ACK,   16'h0000,  8'h00, 5'h00, 1'b1}, 1'b1,
          '{8'hFF, 1'b0, 1'b1, 1'b1, 7'h48}},
        '{'{FUNC_ACK,   16'h0000,  8'h00, 5'h00, 1'b1}, 1'b1,
          '{8'hFF, 1'b0, 1'b1, 1'b1, 7'h50}},
        '{'{FUNC_ACK,   16'h0000,  8'h00, 5'h00, 1'b1}, 1'b1,
          '{8'hFF, 1'b0, 1'b1, 1'b1, 7'h58}},
        '{'{FUNC_ACK,   16'h0000,  8'h00, 5'h00, 1'b1}, 1'b1,
          '{8'hFF, 1'b0, 1'b0, 1'b1, 7'h60}},
        '{'{FUNC_WRITE, ADDR_IF,   8'hE0, 5'h00, 1'b0}, 1'b1,
          '{8'hFF, 1'b1, 1'b0, 1'b0, 7'h00}},
        '{'{FUNC_READ,  ADDR_IF,   8'h00, 5'h00, 1'b0}, 1'b1,
          '{8'hE0, 1'b1, 1'b0, 1'b0, 7'h00}},
        '{'{FUNC_WRITE, ADDR_TAC,  8'h05, 5'h00, 1'b0}, 1'b0, '0},
        '{'{FUNC_WRITE, ADDR_TMA,  8'hAB, 5'h00, 1'b0}, 1'b0, '0},
        '{'{FUNC_WRITE, ADDR_TIMA, 8'hFF, 5'h00, 1'b0}, 1'b0, '0},
        '{'{FUNC_TICK,  16'hFFFF,  8'hFF, 5'h1F, 1'b1}, 1'b0, '0},
        '{'{FUNC_TICK,  16'h0000,  8'h00, 5'h00, 1'b0}, 1'b0, '0},
        '{'{FUNC_TICK,  16'h0000,  8'h00, 5'h00, 1'b0}, 1'b0, '0},
        '{'{FUNC_WRITE, ADDR_DIV,  8'h5A, 5'h00, 1'b0}, 1'b0, '0},
        '{'{FUNC_TICK,  16'h0000,  8'h00, 5'h00, 1'b0}, 1'b0, '0},
        '{'{FUNC_READ,  ADDR_TIMA, 8'h00, 5'h00, 1'b0}, 1'b0, '0},
        '{'{FUNC_READ,  ADDR_DIV,  8'h00, 5'h00, 1'b0}, 1'b0, '0}
    };

    cpu_timer_and_interrupt_controller uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .func          (func),
        .addr          (addr),
        .wdata         (wdata),
        .request_lines (request_lines),
        .master_enable (master_enable),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .rdata         (rdata),
        .addr_hit      (addr_hit),
        .irq_pending   (irq_pending),
        .vector_valid  (vector_valid),
        .vector        (vector)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Applies one accepted beat to the shadow state and returns the result
    // that the block must produce for it.
    function automatic reply_t step_controller(input beat_t b);
        reply_t     r;
        logic       gate;
        logic [4:0] live;
        int         src;
        r = '0;
        r.rdata = UNMAPPED_DATA;
        case (b.op)
            FUNC_TICK:
            begin
                cycle_count = cycle_count + 16'd1;
                case (timer_ctrl[1:0])
                    2'd0:    gate = cycle_count[7];
                    2'd1:    gate = cycle_count[1];
                    2'd2:    gate = cycle_count[3];
                    default: gate = cycle_count[5];
                endcase
                gate = gate & timer_ctrl[2];
                // TIMA moves on a falling gate. A wrap reloads TMA and sets
                // the timer flag in the same tick.
                if (gate_last && !gate)
                begin
                    timer_value = timer_value + 8'd1;
                    if (timer_value == 8'h00)
                    begin
                        timer_value = timer_reload;
                        flag_reg = flag_reg | TIMER_IRQ_BIT;
                    end
                end
                gate_last = gate;
            end
            FUNC_READ:
            begin
                r.addr_hit = 1'b1;
                case (b.addr)
                    ADDR_DIV:  r.rdata = cycle_count[13:6];
                    ADDR_TIMA: r.rdata = timer_value;
                    ADDR_TMA:  r.rdata = timer_reload;
                    ADDR_TAC:  r.rdata = timer_ctrl;
                    ADDR_IF:   r.rdata = flag_reg;
                    ADDR_IE:   r.rdata = enable_reg;
                    default:   r.addr_hit = 1'b0;
                endcase
            end
            FUNC_WRITE:
            begin
                r.addr_hit = 1'b1;
                case (b.addr)
                    ADDR_DIV:  cycle_count = '0;
                    ADDR_TIMA: timer_value = b.wdata;
                    ADDR_TMA:  timer_reload = b.wdata;
                    ADDR_TAC:  timer_ctrl = b.wdata;
                    ADDR_IF:   flag_reg = b.wdata;
                    ADDR_IE:   enable_reg = b.wdata;
                    default:   r.addr_hit = 1'b0;
                endcase
            end
            FUNC_RAISE:
                flag_reg = flag_reg | {3'b000, b.req};
            FUNC_ACK:
            begin
                live = flag_reg[4:0] & enable_reg[4:0];
                if (b.ime && live != 5'd0)
                begin
                    src = 0;
                    while (!live[src])
                        src++;
                    flag_reg[src] = 1'b0;
                    r.vector_valid = 1'b1;
                    r.vector = VECTOR_BASE + 7'(8 * src);
                end
            end
            default:
                ;
        endcase
        r.irq_pending = |(flag_reg[4:0] & enable_reg[4:0]);
        return r;
    endfunction

    // A mixed beat in which every field is random. Bus beats mostly use
    // mapped addresses, and acknowledges mostly have the master enable set.
    function automatic beat_t random_beat();
        beat_t b;
        b.addr = 16'($urandom);
        b.wdata = 8'($urandom);
        b.req = 5'($urandom);
        b.ime = ($urandom_range(0, 3) != 0);
        case ($urandom_range(0, 9))
            0, 1, 2, 3: b.op = FUNC_TICK;
            4, 5:       b.op = FUNC_READ;
            6:          b.op = FUNC_WRITE;
            7:          b.op = FUNC_RAISE;
            default:    b.op = FUNC_ACK;
        endcase
        if ((b.op == FUNC_READ || b.op == FUNC_WRITE) && $urandom_range(0, 4) != 0)
            b.addr = MAPPED_ADDRS[$urandom_range(0, 5)];
        return b;
    endfunction

    // Offers one beat and holds it until the block accepts it. The expected
    // result is queued at the edge where the beat is accepted. An idle gap
    // may follow, and during the gap valid stays low.
    task automatic send_beat(input beat_t b, input logic known, input reply_t known_reply);
        reply_t predicted;
        in_valid <= 1'b1;
        func <= b.op;
        addr <= b.addr;
        wdata <= b.wdata;
        request_lines <= b.req;
        master_enable <= b.ime;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predicted = step_controller(b);
        replies_due.push_back(known ? known_reply : predicted);
        beats_sent++;
        if (idling_on && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 11))
                @(posedge clk);
        end
    endtask

    // Sends one beat with the given operation, address and data. The
    // remaining fields carry random noise.
    task automatic issue(input func_t op, input logic [15:0] a, input logic [7:0] wd);
        beat_t b;
        b = random_beat();
        b.op = op;
        b.addr = a;
        b.wdata = wd;
        send_beat(b, 1'b0, '0);
    endtask

    // A well-formed timer sequence runs in several steps. It first loads
    // TMA and sets TIMA close to wrapping. It then mostly turns the timer on
    // at some rate and ticks it, with stray beats in between. Last, it reads
    // the timer state back and serves the interrupts that are pending.
    task automatic run_timer_scenario();
        logic [7:0] ctrl;
        int         ticks;
        ctrl = 8'($urandom);
        ctrl[2] = ($urandom_range(0, 7) != 0);
        ticks = $urandom_range(10, 90);
        issue(FUNC_WRITE, ADDR_TMA, 8'($urandom));
        issue(FUNC_WRITE, ADDR_TIMA, 8'hF8 | 8'($urandom_range(0, 7)));
        issue(FUNC_WRITE, ADDR_TAC, ctrl);
        if ($urandom_range(0, 1) == 0)
            issue(FUNC_WRITE, ADDR_IE, 8'($urandom));
        repeat (ticks)
        begin
            if ($urandom_range(0, 9) == 0)
                send_beat(random_beat(), 1'b0, '0);
            else
                issue(FUNC_TICK, 16'($urandom), 8'($urandom));
        end
        issue(FUNC_READ, ADDR_TIMA, 8'($urandom));
        issue(FUNC_READ, ADDR_IF, 8'($urandom));
        if ($urandom_range(0, 2) == 0)
            issue(FUNC_RAISE, 16'($urandom), 8'($urandom));
        repeat ($urandom_range(1, 4))
            issue(FUNC_ACK, 16'($urandom), 8'($urandom));
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endtask

    task automatic check_reply(input reply_t got);
        reply_t want;
        if (replies_due.size() == 0)
        begin
            $error("result beat arrived with no expected result waiting");
            mismatches++;
            return;
        end
        want = replies_due.pop_front();
        check_field("rdata", want.rdata, got.rdata);
        check_field("addr_hit", want.addr_hit, got.addr_hit);
        check_field("irq_pending", want.irq_pending, got.irq_pending);
        check_field("vector_valid", want.vector_valid, got.vector_valid);
        check_field("vector", want.vector, got.vector);
    endtask

    // Result side. At each edge an accepted beat is checked, and the next
    // stall value is chosen. One long hold-off, placed in the random part,
    // lets the pipeline fill and pushes back onto the input. Apart from
    // that, stalls come in random bursts while idling is on.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            check_reply({rdata, addr_hit, irq_pending, vector_valid, vector});
        if (!held_off && beats_sent >= HOLD_AT)
        begin
            held_off = 1'b1;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            out_stall <= 1'b1;
        end
        else if (idling_on && $urandom_range(0, 7) == 0)
        begin
            stall_left = $urandom_range(0, 10);
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    // The watchdog counts the cycles in which no beat moves on either
    // channel. The run ends when the count reaches the limit.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial
    begin
        int rate;
        int random_goal;
        repeat (4)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_script[i])
            send_beat(directed_script[i].beat, directed_script[i].known,
                      directed_script[i].reply);

        // The counter sweep goes through the timer rates 1, 2, 3 and then 0
        // without a DIV write. The slowest rate comes last, so the counter
        // has climbed far enough for its bit to fall during the sweep.
        for (rate = 0; rate < 4; rate++)
        begin
            issue(FUNC_WRITE, ADDR_TAC, {5'b00000, 1'b1, 2'(rate + 1)});
            repeat (TICKS_PER_RATE)
                issue(FUNC_TICK, 16'($urandom), 8'($urandom));
        end

        // Random part. Timer sequences and bursts of noise alternate, with
        // idling switched on and off per stretch. The last stretch runs at
        // full rate on both sides.
        random_goal = beats_sent + RANDOM_BEATS;
        while (beats_sent < random_goal)
        begin
            if (beats_sent >= random_goal - CALM_BEATS)
                idling_on = 1'b0;
            else
                idling_on = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 2) != 0)
                run_timer_scenario();
            else
                repeat (10)
                    send_beat(random_beat(), 1'b0, '0);
        end
        in_valid <= 1'b0;

        while (replies_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);

        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
